@@ sv/gpio_port_register_model_assert.svh @@
// assertion macros shared by the port logic
`ifndef GPIO_PORT_REGISTER_MODEL_ASSERT_SVH
`define GPIO_PORT_REGISTER_MODEL_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define GPR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define GPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/gpr_pkg.sv @@
package gpr_pkg;

    // fixed field widths
    localparam int PIN_W       = 16;
    localparam int WORD_W      = 32;
    localparam int EV_W        = 3;
    localparam int OFF_W       = 10;
    localparam int PIN_IDX_W   = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 4;
    localparam int NUM_PINS_DEF = 16;

    // event codes
    localparam logic [EV_W-1:0] EV_READ   = 3'd0;
    localparam logic [EV_W-1:0] EV_WRITE  = 3'd1;
    localparam logic [EV_W-1:0] EV_PIN    = 3'd2;
    localparam logic [EV_W-1:0] EV_ENABLE = 3'd3;
    localparam logic [EV_W-1:0] EV_RESET  = 3'd4;

    // register byte offsets
    localparam logic [OFF_W-1:0] OFF_MODER   = 10'h000;
    localparam logic [OFF_W-1:0] OFF_OTYPER  = 10'h004;
    localparam logic [OFF_W-1:0] OFF_OSPEEDR = 10'h008;
    localparam logic [OFF_W-1:0] OFF_PUPDR   = 10'h00C;
    localparam logic [OFF_W-1:0] OFF_IDR     = 10'h010;
    localparam logic [OFF_W-1:0] OFF_ODR     = 10'h014;
    localparam logic [OFF_W-1:0] OFF_BSRR    = 10'h018;
    localparam logic [OFF_W-1:0] OFF_LCKR    = 10'h01C;
    localparam logic [OFF_W-1:0] OFF_AFRL    = 10'h020;
    localparam logic [OFF_W-1:0] OFF_AFRH    = 10'h024;
    localparam logic [OFF_W-1:0] OFF_BRR     = 10'h028;

    // pin drive codes
    localparam logic [WORD_W-1:0] DRV_LOW  = 32'd0;
    localparam logic [WORD_W-1:0] DRV_HIGH = 32'd1;

    // per-pin mode and pull codes
    localparam logic [1:0] PIN_MODE_IN  = 2'd0;
    localparam logic [1:0] PIN_MODE_OUT = 2'd1;
    localparam logic [1:0] PULL_UP      = 2'd1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FAMILY_F4  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_INDEX = 1'b1;

    // port letters with defaults
    localparam logic [CFG_DATA_W-1:0] PORT_A = 4'd0;
    localparam logic [CFG_DATA_W-1:0] PORT_B = 4'd1;

    // port defaults on the F4 family
    localparam logic [WORD_W-1:0] PA_MODE_DEF  = 32'hA800_0000;
    localparam logic [WORD_W-1:0] PA_PULL_DEF  = 32'h6400_0000;
    localparam logic [WORD_W-1:0] PB_MODE_DEF  = 32'h0000_0280;
    localparam logic [WORD_W-1:0] PB_SPEED_DEF = 32'h0000_00C0;
    localparam logic [WORD_W-1:0] PB_PULL_DEF  = 32'h0000_0100;

    typedef struct packed {
        logic [EV_W-1:0]      mode;
        logic [OFF_W-1:0]     reg_offset;
        logic [WORD_W-1:0]    data;
        logic [PIN_IDX_W-1:0] pin_index;
    } evt_word_t;

    typedef struct packed {
        logic [WORD_W-1:0] read_data;
        logic [PIN_W-1:0]  pin_levels;
        logic [PIN_W-1:0]  irq_fire;
        logic [PIN_W-1:0]  irq_level;
        logic              state_pulse;
        logic              access_error;
        logic [PIN_W-1:0]  short_mask;
    } res_word_t;

endpackage

@@ sv/gpr_evt_if.sv @@
interface gpr_evt_if;
    import gpr_pkg::*;

    logic      valid;
    logic      ready;
    evt_word_t word;

    modport source (output valid, output word, input ready);
    modport sink (input valid, input word, output ready);
endinterface

@@ sv/gpr_res_if.sv @@
interface gpr_res_if;
    import gpr_pkg::*;

    logic      valid;
    logic      ready;
    res_word_t word;

    modport source (output valid, output word, input ready);
    modport sink (input valid, input word, output ready);
endinterface

@@ sv/gpio_port_register_model.sv @@
// channel   role     handshake      word
// evt       sink     valid/ready    mode, reg_offset, data, pin_index
// res       source   valid/ready    read_data .. short_mask
// cfg       write    cfg_we         cfg_index selects family_f4 or port_index
//
// Each word is held in the input register and then lands in the
// result register; throughput is one word per cycle while res is not stalled.
// res.valid rises once the word has passed from the input register into the
// result register, so the earliest result handshake comes after both registers.
// Port state is updated as a word moves from the input to the result register.
// A stall on res holds the result and the input register; evt takes a new
// word whenever the input register is free or moving on.
// rst_n clears all port state, the configuration and both valid flags.
module gpio_port_register_model #(
    parameter int NUM_PINS = gpr_pkg::NUM_PINS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [gpr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gpr_pkg::CFG_DATA_W-1:0]  cfg_data,
    gpr_evt_if.sink                         evt,
    gpr_res_if.source                       res
);
    import gpr_pkg::*;
    `include "gpio_port_register_model_assert.svh"

    localparam logic [PIN_IDX_W:0] PIN_LIMIT = (PIN_IDX_W+1)'(NUM_PINS);

    // pins that exist in this instance
    function automatic logic [PIN_W-1:0] pin_mask_f();
        logic [PIN_W-1:0] m;
        m = '0;
        for (int p = 0; p < PIN_W; p++)
        begin
            if (p < NUM_PINS)
            begin
                m[p] = 1'b1;
            end
        end
        return m;
    endfunction

    localparam logic [PIN_W-1:0] PIN_MASK = pin_mask_f();

    // pipeline control and payload
    logic      in_valid_reg;
    evt_word_t in_word_reg;
    logic      res_valid_reg;
    res_word_t res_word_reg;
    logic      in_move;
    logic      res_free;

    // configuration
    logic                  family_f4_reg;
    logic [CFG_DATA_W-1:0] port_index_reg;

    // port state
    logic [WORD_W-1:0] mode_word_reg, mode_word_next;
    logic [WORD_W-1:0] type_word_reg, type_word_next;
    logic [WORD_W-1:0] speed_word_reg, speed_word_next;
    logic [WORD_W-1:0] pull_word_reg, pull_word_next;
    logic [WORD_W-1:0] output_word_reg, output_word_next;
    logic [WORD_W-1:0] lock_word_reg, lock_word_next;
    logic [WORD_W-1:0] altfn_low_word_reg, altfn_low_word_next;
    logic [WORD_W-1:0] altfn_high_word_reg, altfn_high_word_next;
    logic [PIN_W-1:0]  input_word_reg, input_word_next;
    logic [PIN_W-1:0]  ext_level_reg, ext_level_next;
    logic [PIN_W-1:0]  ext_driven_reg, ext_driven_next;
    logic              enabled_reg, enabled_next;
    logic              reset_held_reg, reset_held_next;

    // per-event results
    res_word_t         res_word_next;
    res_word_t         res_word_fill;
    logic              recompute;
    logic              line_level;
    logic [PIN_W-1:0]  pin_bit;
    logic [PIN_W-1:0]  level_calc;
    logic [PIN_W-1:0]  fire_calc;
    logic [PIN_W-1:0]  short_calc;

    // handshake
    assign res_free  = !res_valid_reg || res.ready;
    assign in_move   = in_valid_reg && res_free;
    assign evt.ready = !in_valid_reg || res_free;
    assign res.valid = res_valid_reg;
    assign res.word  = res_word_reg;

    assign line_level = |in_word_reg.data;
    assign pin_bit    = PIN_W'(1) << in_word_reg.pin_index;

    // event decode and register update
    always_comb
    begin
        mode_word_next       = mode_word_reg;
        type_word_next       = type_word_reg;
        speed_word_next      = speed_word_reg;
        pull_word_next       = pull_word_reg;
        output_word_next     = output_word_reg;
        lock_word_next       = lock_word_reg;
        altfn_low_word_next  = altfn_low_word_reg;
        altfn_high_word_next = altfn_high_word_reg;
        ext_level_next       = ext_level_reg;
        ext_driven_next      = ext_driven_reg;
        enabled_next         = enabled_reg;
        reset_held_next      = reset_held_reg;
        recompute            = 1'b0;
        res_word_next        = '0;

        unique case (in_word_reg.mode)
            EV_READ:
            begin
                if (!enabled_reg)
                begin
                    res_word_next.access_error = 1'b1;
                end
                else
                begin
                    unique case (in_word_reg.reg_offset)
                        OFF_MODER:   res_word_next.read_data = mode_word_reg;
                        OFF_OTYPER:  res_word_next.read_data = type_word_reg;
                        OFF_OSPEEDR: res_word_next.read_data = speed_word_reg;
                        OFF_PUPDR:   res_word_next.read_data = pull_word_reg;
                        OFF_IDR:     res_word_next.read_data = WORD_W'(input_word_reg);
                        OFF_ODR:     res_word_next.read_data = output_word_reg;
                        OFF_BSRR:    res_word_next.read_data = '0;
                        OFF_LCKR:    res_word_next.read_data = lock_word_reg;
                        OFF_AFRL:    res_word_next.read_data = altfn_low_word_reg;
                        OFF_AFRH:    res_word_next.read_data = altfn_high_word_reg;
                        OFF_BRR:     res_word_next.access_error = family_f4_reg;
                        default:     res_word_next.access_error = 1'b1;
                    endcase
                end
            end
            EV_WRITE:
            begin
                if (!enabled_reg)
                begin
                    res_word_next.access_error = 1'b1;
                end
                else
                begin
                    recompute = 1'b1;
                    unique case (in_word_reg.reg_offset)
                        OFF_MODER:   mode_word_next       = in_word_reg.data;
                        OFF_OTYPER:  type_word_next       = in_word_reg.data;
                        OFF_OSPEEDR: speed_word_next      = in_word_reg.data;
                        OFF_PUPDR:   pull_word_next       = in_word_reg.data;
                        OFF_IDR:     output_word_next     = output_word_reg;
                        OFF_ODR:     output_word_next     = in_word_reg.data;
                        OFF_BSRR:
                        begin
                            // clear from the high half, then set, so set wins
                            output_word_next = (output_word_reg
                                & ~WORD_W'(in_word_reg.data[WORD_W-1:PIN_W]))
                                | WORD_W'(in_word_reg.data[PIN_W-1:0]);
                        end
                        OFF_LCKR:    lock_word_next       = in_word_reg.data;
                        OFF_AFRL:    altfn_low_word_next  = in_word_reg.data;
                        OFF_AFRH:    altfn_high_word_next = in_word_reg.data;
                        OFF_BRR:
                        begin
                            if (family_f4_reg)
                            begin
                                res_word_next.access_error = 1'b1;
                            end
                            else
                            begin
                                output_word_next = output_word_reg
                                    & ~WORD_W'(in_word_reg.data[PIN_W-1:0]);
                            end
                        end
                        default:     res_word_next.access_error = 1'b1;
                    endcase
                end
            end
            EV_PIN:
            begin
                // external drive, anything above high releases the pin
                if ({1'b0, in_word_reg.pin_index} < PIN_LIMIT)
                begin
                    recompute = 1'b1;
                    if (in_word_reg.data == DRV_LOW)
                    begin
                        ext_driven_next = ext_driven_reg | pin_bit;
                        ext_level_next  = ext_level_reg & ~pin_bit;
                    end
                    else if (in_word_reg.data == DRV_HIGH)
                    begin
                        ext_driven_next = ext_driven_reg | pin_bit;
                        ext_level_next  = ext_level_reg | pin_bit;
                    end
                    else
                    begin
                        ext_driven_next = ext_driven_reg & ~pin_bit;
                    end
                end
            end
            EV_ENABLE:
            begin
                if (line_level != enabled_reg)
                begin
                    enabled_next = line_level;
                    recompute    = 1'b1;
                end
            end
            EV_RESET:
            begin
                if (line_level != reset_held_reg)
                begin
                    reset_held_next = line_level;
                    recompute       = 1'b1;
                    if (line_level)
                    begin
                        // reload family and port defaults
                        mode_word_next       = '0;
                        type_word_next       = '0;
                        speed_word_next      = '0;
                        pull_word_next       = '0;
                        output_word_next     = '0;
                        lock_word_next       = '0;
                        altfn_low_word_next  = '0;
                        altfn_high_word_next = '0;
                        if (family_f4_reg && port_index_reg == PORT_A)
                        begin
                            mode_word_next = PA_MODE_DEF;
                            pull_word_next = PA_PULL_DEF;
                        end
                        else if (family_f4_reg && port_index_reg == PORT_B)
                        begin
                            mode_word_next  = PB_MODE_DEF;
                            speed_word_next = PB_SPEED_DEF;
                            pull_word_next  = PB_PULL_DEF;
                        end
                    end
                end
            end
            default:
            begin
                recompute = 1'b0;
            end
        endcase
    end

    // per-pin level, interrupt and short detection on the updated words
    always_comb
    begin
        level_calc = '0;
        fire_calc  = '0;
        short_calc = '0;
        for (int p = 0; p < PIN_W; p++)
        begin
            if (p < NUM_PINS)
            begin
                if (ext_driven_next[p])
                begin
                    level_calc[p] = ext_level_next[p];
                end
                else if (mode_word_next[2*p +: 2] == PIN_MODE_OUT)
                begin
                    level_calc[p] = output_word_next[p];
                end
                else
                begin
                    level_calc[p] = (pull_word_next[2*p +: 2] == PULL_UP);
                end
                short_calc[p] = ext_driven_next[p]
                    && (mode_word_next[2*p +: 2] == PIN_MODE_OUT);
                fire_calc[p]  = (level_calc[p] != input_word_reg[p])
                    && (mode_word_next[2*p +: 2] == PIN_MODE_IN);
            end
        end
    end

    // result word
    always_comb
    begin
        input_word_next = recompute ? (level_calc & PIN_MASK) : input_word_reg;
        res_word_fill             = res_word_next;
        res_word_fill.pin_levels  = input_word_next;
        res_word_fill.state_pulse = recompute;
        res_word_fill.irq_fire    = recompute ? fire_calc : '0;
        res_word_fill.irq_level   = recompute ? (level_calc & fire_calc) : '0;
        res_word_fill.short_mask  = recompute ? short_calc : '0;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (evt.ready)
        begin
            in_valid_reg <= evt.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt.valid && evt.ready)
        begin
            in_word_reg <= evt.word;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_free)
        begin
            res_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_move)
        begin
            res_word_reg <= res_word_fill;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            family_f4_reg  <= 1'b0;
            port_index_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FAMILY_F4:  family_f4_reg  <= cfg_data[0];
                CFG_PORT_INDEX: port_index_reg <= cfg_data;
                default:        family_f4_reg  <= family_f4_reg;
            endcase
        end
    end

    // port state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_word_reg       <= '0;
            type_word_reg       <= '0;
            speed_word_reg      <= '0;
            pull_word_reg       <= '0;
            output_word_reg     <= '0;
            lock_word_reg       <= '0;
            altfn_low_word_reg  <= '0;
            altfn_high_word_reg <= '0;
            input_word_reg      <= '0;
            ext_level_reg       <= '0;
            ext_driven_reg      <= '0;
            enabled_reg         <= 1'b0;
            reset_held_reg      <= 1'b0;
        end
        else if (in_move)
        begin
            mode_word_reg       <= mode_word_next;
            type_word_reg       <= type_word_next;
            speed_word_reg      <= speed_word_next;
            pull_word_reg       <= pull_word_next;
            output_word_reg     <= output_word_next;
            lock_word_reg       <= lock_word_next;
            altfn_low_word_reg  <= altfn_low_word_next;
            altfn_high_word_reg <= altfn_high_word_next;
            input_word_reg      <= input_word_next;
            ext_level_reg       <= ext_level_next;
            ext_driven_reg      <= ext_driven_next;
            enabled_reg         <= enabled_next;
            reset_held_reg      <= reset_held_next;
        end
    end

    // checks
    `GPR_ASSERT_NOW(a_irq_needs_pulse, res_valid_reg && !res_word_reg.state_pulse,
        res_word_reg.irq_fire == '0 && res_word_reg.short_mask == '0,
        "interrupt or short without recompute")
    `GPR_ASSERT_NOW(a_read_no_pulse, res_valid_reg && res_word_reg.read_data != '0,
        !res_word_reg.state_pulse && !res_word_reg.access_error,
        "read data with recompute or error")
    `GPR_ASSERT_NOW(a_level_in_fire, res_valid_reg,
        (res_word_reg.irq_level & ~res_word_reg.irq_fire) == '0,
        "interrupt level outside fire mask")
    `GPR_ASSERT_NOW(a_unused_pins, 1'b1, (input_word_reg & ~PIN_MASK) == '0,
        "level on a pin beyond the port")
    `GPR_ASSERT_NEXT(a_move_fills_result, in_move, res_valid_reg,
        "moved word not in result register")

endmodule
